@@ rtl/complex_arithmetic_unit_macros.svh @@
// Assertion macros shared by the complex arithmetic unit RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition is followed by another on the next edge
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (nxt)) \
        else $error(msg);

`endif

@@ rtl/cau_pkg.sv @@
// Package for the complex arithmetic unit: widths, opcodes, status codes,
// pipeline word types and the saturation function. No dependencies.
`timescale 1ns / 1ps
package cau_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int PART_WIDTH = 16;
    localparam int PW         = PART_WIDTH;
    localparam int PRW        = 2 * PART_WIDTH;          // product width
    localparam int SW         = 2 * PART_WIDTH + 1;      // sum of two products
    localparam int RW         = 3 * PART_WIDTH + FRAC_BITS; // divider remainder
    localparam int DIV_STEPS  = PART_WIDTH;
    localparam int LATENCY    = 5 + DIV_STEPS;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;

    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_SAT = 2'd1;
    localparam logic [1:0] STAT_DZ  = 2'd2;

    localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (PW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_MIN = SW'(-(64'sd1 <<< (PW - 1)));

    typedef logic signed [PW-1:0] t_part;

    typedef struct packed {
        t_part      val;
        logic       sat;
    } t_sat;

    // Finished result of the non-divide operations
    typedef struct packed {
        t_part      res_re;
        t_part      res_im;
        logic       is_equal;
        logic [1:0] status;
    } t_res;

    // Divider state that travels down the step stages
    typedef struct packed {
        logic          is_div;
        logic          dz;
        logic          ovf_re;
        logic          ovf_im;
        logic          neg_re;
        logic          neg_im;
        logic [RW-1:0] rem_re;
        logic [RW-1:0] rem_im;
        logic [RW-1:0] dsh;
        logic [PW-1:0] q_re;
        logic [PW-1:0] q_im;
    } t_div;

    typedef struct packed {
        t_res res;
        t_div div;
    } t_word;

    // Clamp a wide signed value to one part
    function automatic t_sat sat_part(input logic signed [SW-1:0] v);
        t_sat r;
        if (v > SAT_MAX) begin
            r.val = SAT_MAX[PW-1:0];
            r.sat = 1'b1;
        end else if (v < SAT_MIN) begin
            r.val = SAT_MIN[PW-1:0];
            r.sat = 1'b1;
        end else begin
            r.val = v[PW-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ rtl/cau_front.sv @@
// Front stages: operand register, multipliers, product sums, then
// saturation of add/sub/mul and divider setup. Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [2:0]     i_cmd,
    input  cau_pkg::t_part i_a_re,
    input  cau_pkg::t_part i_a_im,
    input  cau_pkg::t_part i_b_re,
    input  cau_pkg::t_part i_b_im,
    output logic           o_valid,
    output cau_pkg::t_word o_word
);
    import cau_pkg::*;

    // stage 1: operands
    logic       r1_v;
    logic [2:0] r1_cmd;
    t_part      r1_ar, r1_ai, r1_br, r1_bi;

    // stage 2: products
    logic                  r2_v, n2_eq;
    logic [2:0]            r2_cmd;
    logic signed [PRW-1:0] r2_p_rr, r2_p_ii, r2_p_ri, r2_p_ir, r2_p_bb_r, r2_p_bb_i;
    logic signed [SW-1:0]  r2_as_re, r2_as_im, n2_as_re, n2_as_im;
    logic                  r2_eq;

    // stage 3: sums
    logic                 r3_v;
    logic [2:0]           r3_cmd;
    logic signed [SW-1:0] r3_pre_re, r3_pre_im, n3_pre_re, n3_pre_im;
    logic [PRW-1:0]       r3_den;
    logic                 r3_eq;

    // stage 4
    logic                 r4_v;
    t_word                r4_word, n4_word;
    t_sat                 s_re, s_im;
    logic signed [SW-1:0] sh_re, sh_im, abs_re, abs_im;
    logic [RW-1:0]        num_re, num_im, den_top;

    // hold valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // register operands
    always_ff @(posedge i_clk) begin
        r1_cmd <= i_cmd;
        r1_ar  <= i_a_re;
        r1_ai  <= i_a_im;
        r1_br  <= i_b_re;
        r1_bi  <= i_b_im;
    end

    // add/sub and compare next to the multipliers
    always_comb begin
        if (r1_cmd == CMD_SUB) begin
            n2_as_re = SW'(r1_ar) - SW'(r1_br);
            n2_as_im = SW'(r1_ai) - SW'(r1_bi);
        end else begin
            n2_as_re = SW'(r1_ar) + SW'(r1_br);
            n2_as_im = SW'(r1_ai) + SW'(r1_bi);
        end
        n2_eq = (r1_cmd == CMD_CMP) && (r1_ar == r1_br) && (r1_ai == r1_bi);
    end

    always_ff @(posedge i_clk) begin
        r2_cmd    <= r1_cmd;
        r2_p_rr   <= PRW'(r1_ar) * PRW'(r1_br);
        r2_p_ii   <= PRW'(r1_ai) * PRW'(r1_bi);
        r2_p_ri   <= PRW'(r1_ar) * PRW'(r1_bi);
        r2_p_ir   <= PRW'(r1_br) * PRW'(r1_ai);
        r2_p_bb_r <= PRW'(r1_br) * PRW'(r1_br);
        r2_p_bb_i <= PRW'(r1_bi) * PRW'(r1_bi);
        r2_as_re  <= n2_as_re;
        r2_as_im  <= n2_as_im;
        r2_eq     <= n2_eq;
    end

    // pick the wide pre-result for each opcode
    always_comb begin
        case (r2_cmd)
            CMD_MUL: begin
                n3_pre_re = SW'(r2_p_rr) - SW'(r2_p_ii);
                n3_pre_im = SW'(r2_p_ri) + SW'(r2_p_ir);
            end
            CMD_DIV: begin
                n3_pre_re = SW'(r2_p_rr) + SW'(r2_p_ii);
                n3_pre_im = SW'(r2_p_ir) - SW'(r2_p_ri);
            end
            default: begin
                n3_pre_re = r2_as_re;
                n3_pre_im = r2_as_im;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r3_cmd    <= r2_cmd;
        r3_pre_re <= n3_pre_re;
        r3_pre_im <= n3_pre_im;
        r3_den    <= PRW'(r2_p_bb_r) + PRW'(r2_p_bb_i);
        r3_eq     <= r2_eq;
    end

    // saturate direct results and set up the divider
    always_comb begin
        if (r3_cmd == CMD_MUL) begin
            sh_re = r3_pre_re >>> FRAC_BITS;
            sh_im = r3_pre_im >>> FRAC_BITS;
        end else begin
            sh_re = r3_pre_re;
            sh_im = r3_pre_im;
        end
        s_re = sat_part(sh_re);
        s_im = sat_part(sh_im);

        n4_word = '0;
        case (r3_cmd)
            CMD_ADD, CMD_SUB, CMD_MUL: begin
                n4_word.res.res_re = s_re.val;
                n4_word.res.res_im = s_im.val;
                n4_word.res.status = (s_re.sat || s_im.sat) ? STAT_SAT : STAT_OK;
            end
            CMD_CMP: begin
                n4_word.res.is_equal = r3_eq;
            end
            default: begin
                n4_word.res = '0;
            end
        endcase

        abs_re  = r3_pre_re[SW-1] ? -r3_pre_re : r3_pre_re;
        abs_im  = r3_pre_im[SW-1] ? -r3_pre_im : r3_pre_im;
        num_re  = RW'(abs_re[PRW-1:0]) << FRAC_BITS;
        num_im  = RW'(abs_im[PRW-1:0]) << FRAC_BITS;
        den_top = RW'(r3_den) << PW;

        n4_word.div.is_div = (r3_cmd == CMD_DIV);
        n4_word.div.dz     = (r3_den == '0);
        n4_word.div.neg_re = r3_pre_re[SW-1];
        n4_word.div.neg_im = r3_pre_im[SW-1];
        n4_word.div.ovf_re = (num_re >= den_top);
        n4_word.div.ovf_im = (num_im >= den_top);
        n4_word.div.rem_re = num_re;
        n4_word.div.rem_im = num_im;
        n4_word.div.dsh    = RW'(r3_den) << (PW - 1);
        n4_word.div.q_re   = '0;
        n4_word.div.q_im   = '0;
    end

    always_ff @(posedge i_clk) begin
        r4_word <= n4_word;
    end

    assign o_valid = r4_v;
    assign o_word  = r4_word;

endmodule

@@ rtl/cau_div_step.sv @@
// One restoring division step for both parts, registered.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cau_pkg::t_word i_word,
    output logic           o_valid,
    output cau_pkg::t_word o_word
);
    import cau_pkg::*;

    logic  r_valid;
    t_word r_word, n_word;
    logic  bit_re, bit_im;

    // subtract the shifted divisor where it fits, shift in the quotient bit
    always_comb begin
        n_word = i_word;
        bit_re = (i_word.div.rem_re >= i_word.div.dsh);
        bit_im = (i_word.div.rem_im >= i_word.div.dsh);
        if (bit_re) begin
            n_word.div.rem_re = i_word.div.rem_re - i_word.div.dsh;
        end
        if (bit_im) begin
            n_word.div.rem_im = i_word.div.rem_im - i_word.div.dsh;
        end
        n_word.div.q_re = {i_word.div.q_re[PW-2:0], bit_re};
        n_word.div.q_im = {i_word.div.q_im[PW-2:0], bit_im};
        n_word.div.dsh  = i_word.div.dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ rtl/complex_arithmetic_unit.sv @@
// Complex ALU on Q8.8 parts: add, subtract, multiply, divide, compare.
// Pipeline: LATENCY = 21 register stages (4 front, one per quotient bit, one output).
// Throughput: one word per cycle; busy is low whenever out of reset.
// Reset (synchronous, active low) clears all valid bits; o_valid cannot stall.
// Depends on cau_pkg, cau_front, cau_div_step and the macros header.
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_macros.svh"
module complex_arithmetic_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [2:0]     i_cmd,
    input  cau_pkg::t_part i_a_re,
    input  cau_pkg::t_part i_a_im,
    input  cau_pkg::t_part i_b_re,
    input  cau_pkg::t_part i_b_im,
    output logic           o_valid,
    output cau_pkg::t_part o_res_re,
    output cau_pkg::t_part o_res_im,
    output logic           o_is_equal,
    output logic [1:0]     o_status
);
    import cau_pkg::*;

    logic  st_valid [DIV_STEPS+1];
    t_word st_word  [DIV_STEPS+1];

    logic                 r_valid;
    t_res                 r_res, n_res;
    t_div                 dv;
    logic signed [SW-1:0] q_re_s, q_im_s;
    t_sat                 s_re, s_im;

    assign busy = ~i_rst_n;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_cmd   (i_cmd),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .o_valid (st_valid[0]),
        .o_word  (st_word[0])
    );

    // one stage per quotient bit
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .i_word  (st_word[g]),
            .o_valid (st_valid[g+1]),
            .o_word  (st_word[g+1])
        );
    end

    // apply sign and saturation to the quotients
    always_comb begin
        dv     = st_word[DIV_STEPS].div;
        q_re_s = signed'(SW'(dv.q_re));
        q_im_s = signed'(SW'(dv.q_im));
        s_re   = sat_part(dv.neg_re ? -q_re_s : q_re_s);
        s_im   = sat_part(dv.neg_im ? -q_im_s : q_im_s);
        if (dv.ovf_re) begin
            s_re.val = dv.neg_re ? SAT_MIN[PW-1:0] : SAT_MAX[PW-1:0];
            s_re.sat = 1'b1;
        end
        if (dv.ovf_im) begin
            s_im.val = dv.neg_im ? SAT_MIN[PW-1:0] : SAT_MAX[PW-1:0];
            s_im.sat = 1'b1;
        end
        if (!dv.is_div) begin
            n_res = st_word[DIV_STEPS].res;
        end else if (dv.dz) begin
            n_res        = '0;
            n_res.status = STAT_DZ;
        end else begin
            n_res.res_re   = s_re.val;
            n_res.res_im   = s_im.val;
            n_res.is_equal = 1'b0;
            n_res.status   = (s_re.sat || s_im.sat) ? STAT_SAT : STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= st_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid    = r_valid;
    assign o_res_re   = r_res.res_re;
    assign o_res_im   = r_res.res_im;
    assign o_is_equal = r_res.is_equal;
    assign o_status   = r_res.status;

    `CAU_ASSERT(a_latency, i_clk, i_rst_n, o_valid == $past(start && !busy, LATENCY), "result strobe out of step with accepted words")
    `CAU_ASSERT(a_eq_clean, i_clk, i_rst_n, (o_valid && o_is_equal) |-> (o_status == STAT_OK && o_res_re == '0 && o_res_im == '0), "compare result carries nonzero parts")
    `CAU_ASSERT(a_dz_zero, i_clk, i_rst_n, (o_valid && o_status == STAT_DZ) |-> (o_res_re == '0 && o_res_im == '0 && !o_is_equal), "divide by zero result not cleared")
    `CAU_ASSERT_NEXT(a_div_track, i_clk, i_rst_n, st_valid[DIV_STEPS] && st_word[DIV_STEPS].div.is_div, o_valid && !o_is_equal, "divide word lost at output stage")

endmodule
